// ===== hw/rtl/rrpq_pkg.sv =====
package rrpq_pkg;

  localparam int FIELD_PTR_W   = 32;
  localparam int FIELD_WORDS_W = 16;
  localparam int FIELD_SLOT_W  = 3;
  localparam int STATUS_W      = 2;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic                     still_running;
    logic [FIELD_PTR_W-1:0]   stack_pointer;
    logic [FIELD_WORDS_W-1:0] stack_words;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     next_valid;
    logic [FIELD_PTR_W-1:0]   next_stack_pointer;
    logic [FIELD_SLOT_W-1:0]  next_slot;
    logic                     released_valid;
    logic [FIELD_PTR_W-1:0]   released_stack_base;
    logic [FIELD_WORDS_W-1:0] released_stack_words;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

endpackage

// ===== hw/rtl/rrpq_slot_table.sv =====
module rrpq_slot_table import rrpq_pkg::*; #(
  parameter int DEPTH  = 8,
  parameter int PTR_W  = 32,
  parameter int SLOT_W = 3
) (
  input  logic                     clk,
  input  logic                     info_we,
  input  logic [SLOT_W-1:0]        info_waddr,
  input  logic [PTR_W-1:0]         base_wdata,
  input  logic [FIELD_WORDS_W-1:0] size_wdata,
  input  logic                     saved_we,
  input  logic [SLOT_W-1:0]        saved_waddr,
  input  logic [PTR_W-1:0]         saved_wdata,
  input  logic [SLOT_W-1:0]        info_raddr,
  input  logic [SLOT_W-1:0]        saved_raddr,
  output logic [PTR_W-1:0]         base_rdata,
  output logic [FIELD_WORDS_W-1:0] size_rdata,
  output logic [PTR_W-1:0]         saved_rdata
);

  logic [PTR_W-1:0]         base_mem  [DEPTH];
  logic [FIELD_WORDS_W-1:0] size_mem  [DEPTH];
  logic [PTR_W-1:0]         saved_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (info_we) begin
      base_mem[info_waddr] <= base_wdata;
      size_mem[info_waddr] <= size_wdata;
    end
    base_rdata <= base_mem[info_raddr];
    size_rdata <= size_mem[info_raddr];
  end

  always_ff @(posedge clk) begin
    if (saved_we) begin
      saved_mem[saved_waddr] <= saved_wdata;
    end
    saved_rdata <= saved_mem[saved_raddr];
  end

endmodule

// ===== hw/rtl/rrpq_ready_fifo.sv =====
module rrpq_ready_fifo #(
  parameter int DEPTH  = 8,
  parameter int SLOT_W = 3,
  parameter int CNT_W  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [SLOT_W-1:0] push_slot,
  input  logic              pop,
  output logic [SLOT_W-1:0] head_slot,
  output logic [CNT_W-1:0]  count
);

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(DEPTH - 1);

  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_slot;
    end
    head_slot <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/round_robin_process_queue.sv =====
// Flow: a create goes from the idle state that accepts it straight to commit; a select
// passes through the lookup state, where the table is read, before commit. The block
// handles one transaction at a time and accepts a new request only in the idle state.
// A result waiting at rsp does not block acceptance of the next request; the commit of
// that request waits until rsp is free.
// Reset clears the slot in-use flags, queue pointers and current process; table
// and queue memories are not cleared.
module round_robin_process_queue import rrpq_pkg::*; #(
  parameter int MAX_PROCESSES = 8,
  parameter int POINTER_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

  state_t state;
  state_t state_next;

  req_item_t               cur_req;
  logic [MAX_PROCESSES-1:0] in_use;
  logic [MAX_PROCESSES-1:0] in_use_next;
  logic [SLOT_W-1:0]       current_index;
  logic                    current_present;

  logic                     commit_fire;
  logic [POINTER_BITS-1:0]  ptr_in;
  logic [63:0]              ptr_wide;
  logic [SLOT_W-1:0]        free_slot;
  logic                     has_free;
  logic                     is_create;
  logic                     create_ok;
  logic                     push_cur;
  logic                     release_cur;
  logic                     fifo_nonempty;
  logic                     dispatch;
  logic                     from_cur;
  logic [SLOT_W-1:0]        disp_slot;
  logic [POINTER_BITS-1:0]  disp_ptr;
  logic [63:0]              disp_ptr_wide;
  logic [63:0]              rel_base_wide;
  logic [6:0]               disp_slot_wide;
  rsp_item_t                rsp_next;

  logic                     fifo_push;
  logic [SLOT_W-1:0]        fifo_push_slot;
  logic                     fifo_pop;
  logic [SLOT_W-1:0]        fifo_head_slot;
  logic [CNT_W-1:0]         fifo_count;

  logic                     saved_we;
  logic [SLOT_W-1:0]        saved_waddr;
  logic [POINTER_BITS-1:0]  base_rdata;
  logic [FIELD_WORDS_W-1:0] size_rdata;
  logic [POINTER_BITS-1:0]  saved_rdata;

  rrpq_ready_fifo #(
    .DEPTH  (MAX_PROCESSES),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_slot (fifo_push_slot),
    .pop       (fifo_pop),
    .head_slot (fifo_head_slot),
    .count     (fifo_count)
  );

  rrpq_slot_table #(
    .DEPTH  (MAX_PROCESSES),
    .PTR_W  (POINTER_BITS),
    .SLOT_W (SLOT_W)
  ) u_table (
    .clk         (clk),
    .info_we     (commit_fire && create_ok),
    .info_waddr  (free_slot),
    .base_wdata  (ptr_in),
    .size_wdata  (cur_req.stack_words),
    .saved_we    (saved_we),
    .saved_waddr (saved_waddr),
    .saved_wdata (ptr_in),
    .info_raddr  (current_index),
    .saved_raddr (fifo_head_slot),
    .base_rdata  (base_rdata),
    .size_rdata  (size_rdata),
    .saved_rdata (saved_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.operation == OP_CREATE) ? ST_COMMIT : ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    commit_fire = 1'b0;
    case (state)
      ST_IDLE:   req_ready = 1'b1;
      ST_LOOKUP: req_ready = 1'b0;
      ST_COMMIT: commit_fire = !rsp_valid || rsp_ready;
      default:   req_ready = 1'b0;
    endcase
  end

  always_comb begin
    free_slot = '0;
    for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ptr_wide      = 64'(cur_req.stack_pointer);
    ptr_in        = ptr_wide[POINTER_BITS-1:0];
    has_free      = !(&in_use);
    is_create     = cur_req.operation == OP_CREATE;
    create_ok     = is_create && (ptr_in != '0) && has_free && (fifo_count < CNT_MAX);
    push_cur      = !is_create && current_present && cur_req.still_running;
    release_cur   = !is_create && current_present && !cur_req.still_running;
    fifo_nonempty = fifo_count != '0;
    from_cur      = push_cur && !fifo_nonempty;
    dispatch      = !is_create && (fifo_nonempty || push_cur);
    disp_slot     = from_cur ? current_index : fifo_head_slot;
    disp_ptr      = from_cur ? ptr_in : saved_rdata;

    fifo_push      = commit_fire && (create_ok || (push_cur && fifo_count < CNT_MAX));
    fifo_push_slot = is_create ? free_slot : current_index;
    fifo_pop       = commit_fire && dispatch;
    saved_we       = commit_fire && (create_ok || push_cur);
    saved_waddr    = is_create ? free_slot : current_index;

    in_use_next = in_use;
    if (create_ok) begin
      in_use_next[free_slot] = 1'b1;
    end
    if (release_cur) begin
      in_use_next[current_index] = 1'b0;
    end

    disp_ptr_wide  = 64'(disp_ptr);
    rel_base_wide  = 64'(base_rdata);
    disp_slot_wide = 7'(disp_slot);

    rsp_next = '0;
    if (is_create) begin
      if (ptr_in == '0) begin
        rsp_next.status = STATUS_NULL;
      end else if (!create_ok) begin
        rsp_next.status = STATUS_FULL;
      end else begin
        rsp_next.status = STATUS_OK;
      end
    end else begin
      rsp_next.status = STATUS_OK;
      if (dispatch) begin
        rsp_next.next_valid         = 1'b1;
        rsp_next.next_stack_pointer = disp_ptr_wide[FIELD_PTR_W-1:0];
        rsp_next.next_slot          = disp_slot_wide[FIELD_SLOT_W-1:0];
      end
      if (release_cur) begin
        rsp_next.released_valid       = 1'b1;
        rsp_next.released_stack_base  = rel_base_wide[FIELD_PTR_W-1:0];
        rsp_next.released_stack_words = size_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      in_use          <= '0;
      current_index   <= '0;
      current_present <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_fire) begin
        in_use    <= in_use_next;
        rsp_valid <= 1'b1;
        if (!is_create) begin
          current_present <= dispatch;
          current_index   <= dispatch ? disp_slot : '0;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur_req <= req;
    end
    if (commit_fire) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_MAX)
    else $error("ready queue count exceeds table depth");

  a_slots_cover_queue: assert property (@(posedge clk) disable iff (rst)
    (32'(fifo_count) + 32'(current_present)) <= 32'($countones(in_use)))
    else $error("queued or current processes exceed slots in use");

  a_dispatch_in_use: assert property (@(posedge clk) disable iff (rst)
    (commit_fire && dispatch) |-> in_use[disp_slot])
    else $error("dispatched slot is not in use");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != ST_IDLE))
    else $error("accepted transaction did not start processing");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rrpq_pkg::*;

  localparam int SLOTS = 8;

  typedef struct {
    req_item_t item;
    bit        drain_first;
  } pending_t;

  logic      clk;
  logic      rst;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  pending_t  pending_requests[$];
  rsp_item_t expected_results[$];
  int        requests_accepted = 0;
  int        results_checked = 0;
  int        mismatches = 0;

  logic                     holding = 1'b0;
  logic                     hold_done = 1'b0;
  int                       hold_cycles = 0;

  logic [FIELD_PTR_W-1:0]   table_base[SLOTS];
  logic [FIELD_PTR_W-1:0]   table_saved[SLOTS];
  logic [FIELD_WORDS_W-1:0] table_words[SLOTS];
  bit   [SLOTS-1:0]         table_busy = '0;
  logic [FIELD_SLOT_W-1:0]  ready_order[$];
  logic [FIELD_SLOT_W-1:0]  running_slot = '0;
  bit                       running_known = 1'b0;

  round_robin_process_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic rsp_item_t schedule_step(input req_item_t r);
    rsp_item_t               o;
    int                      free_slot;
    logic [FIELD_SLOT_W-1:0] cur;
    o = '0;
    if (r.operation == OP_CREATE) begin
      if (r.stack_pointer == '0) begin
        o.status = STATUS_NULL;
      end else begin
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!table_busy[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0 || ready_order.size() >= SLOTS) begin
          o.status = STATUS_FULL;
        end else begin
          table_busy[free_slot] = 1'b1;
          table_base[free_slot] = r.stack_pointer;
          table_saved[free_slot] = r.stack_pointer;
          table_words[free_slot] = r.stack_words;
          ready_order.push_back(free_slot[FIELD_SLOT_W-1:0]);
        end
      end
    end else begin
      cur = running_slot;
      if (running_known) begin
        if (r.still_running) begin
          table_saved[cur] = r.stack_pointer;
          if (ready_order.size() < SLOTS) ready_order.push_back(cur);
        end else begin
          o.released_valid = 1'b1;
          o.released_stack_base = table_base[cur];
          o.released_stack_words = table_words[cur];
          table_busy[cur] = 1'b0;
        end
      end
      if (ready_order.size() > 0) begin
        running_slot = ready_order.pop_front();
        running_known = 1'b1;
        o.next_valid = 1'b1;
        o.next_stack_pointer = table_saved[running_slot];
        o.next_slot = running_slot;
      end else begin
        running_known = 1'b0;
        running_slot = '0;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch on transaction %0d: got %h, expected %h",
             $time, what, results_checked, got, want);
  endtask

  task automatic check_result(input rsp_item_t got);
    rsp_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", '0, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.next_valid !== want.next_valid)
      report_mismatch("next_valid", 32'(got.next_valid), 32'(want.next_valid));
    if (got.next_stack_pointer !== want.next_stack_pointer)
      report_mismatch("next_stack_pointer", got.next_stack_pointer, want.next_stack_pointer);
    if (got.next_slot !== want.next_slot)
      report_mismatch("next_slot", 32'(got.next_slot), 32'(want.next_slot));
    if (got.released_valid !== want.released_valid)
      report_mismatch("released_valid", 32'(got.released_valid), 32'(want.released_valid));
    if (got.released_stack_base !== want.released_stack_base)
      report_mismatch("released_stack_base", got.released_stack_base,
                      want.released_stack_base);
    if (got.released_stack_words !== want.released_stack_words)
      report_mismatch("released_stack_words", 32'(got.released_stack_words),
                      32'(want.released_stack_words));
  endtask

  function automatic void queue_create(input logic [31:0] ptr, input logic [15:0] words,
                                       input bit drain);
    pending_t p;
    p.item = '0;
    p.item.operation = OP_CREATE;
    p.item.still_running = 1'($urandom_range(1));
    p.item.stack_pointer = ptr;
    p.item.stack_words = words;
    p.drain_first = drain;
    pending_requests.push_back(p);
  endfunction

  function automatic void queue_select(input bit running, input logic [31:0] ptr,
                                       input bit drain);
    pending_t p;
    p.item = '0;
    p.item.operation = OP_SELECT;
    p.item.still_running = running;
    p.item.stack_pointer = ptr;
    p.item.stack_words = 16'($urandom_range(16'hffff));
    p.drain_first = drain;
    pending_requests.push_back(p);
  endfunction

  function automatic int pick_percent();
    case ($urandom_range(2))
      0: return 20;
      1: return 50;
      default: return 85;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_results.push_back(schedule_step(req));
        requests_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (pending_requests.size() > 0
            && !(pending_requests[0].drain_first && expected_results.size() > 0)
            && !((requests_accepted < 1200 || requests_accepted >= 1500)
                 && $urandom_range(99) < 10)) begin
          req <= pending_requests[0].item;
          pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      hold_done <= 1'b0;
      hold_cycles <= 0;
    end else if (holding) begin
      if (hold_cycles == 0) holding <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && requests_accepted >= 400) begin
      holding <= 1'b1;
      hold_done <= 1'b1;
      hold_cycles <= 300;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        check_result(rsp);
        results_checked++;
      end
      rsp_ready <= !holding
                   && !((results_checked < 1200 || results_checked >= 1500)
                        && $urandom_range(99) < 10);
    end
  end

  initial begin
    int create_pct;
    int end_pct;
    rst = 1'b1;

    queue_select(1'b1, 32'h0, 1'b0);
    queue_select(1'b0, 32'h0, 1'b0);
    queue_create(32'h0, 16'h1234, 1'b0);
    queue_create(32'hffff_ffff, 16'hffff, 1'b0);
    queue_create(32'h0000_0001, 16'h0000, 1'b0);
    queue_select(1'b1, 32'h0, 1'b0);
    queue_select(1'b1, 32'hffff_ffff, 1'b0);
    queue_select(1'b0, $urandom, 1'b0);
    queue_select(1'b0, $urandom, 1'b0);
    queue_select(1'b0, $urandom, 1'b0);
    for (int k = 0; k < SLOTS + 1; k++)
      queue_create($urandom | 32'h1, 16'($urandom_range(16'hffff)), 1'b0);
    queue_create(32'h0, 16'hffff, 1'b0);
    queue_select(1'b1, 32'h8000_0000, 1'b0);
    queue_select(1'b0, 32'h7fff_ffff, 1'b0);
    queue_create(32'h5555_aaaa, 16'h8001, 1'b0);

    create_pct = 50;
    end_pct = 40;
    for (int n = 0; n < 1880; n++) begin
      if (n % 100 == 0) begin
        create_pct = pick_percent();
        end_pct = pick_percent();
      end
      if ($urandom_range(99) < create_pct)
        queue_create(($urandom_range(19) == 0) ? 32'h0 : $urandom,
                     16'($urandom_range(16'hffff)), n == 0 || n == 900);
      else
        queue_select($urandom_range(99) >= end_pct, $urandom, n == 0 || n == 900);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
